// ----- sv/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types, constants and helpers for the JSON string unescaper
// Holds the phase and result codes, the per-item result group and the
// hex-digit and UTF-8 encode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Default cap on the output buffer size
  localparam int unsigned MAX_LIMIT_DEF = 1024;

  // Configuration register
  localparam int unsigned CFG_W       = 11;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd64;

  // Result field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned STAT_W = 2;

  // Data bytes one item can produce
  localparam int unsigned MAX_BYTES = 4;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6e;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;

  // Surrogate ranges
  localparam logic [15:0] HI_SUR_MIN = 16'hd800;
  localparam logic [15:0] HI_SUR_MAX = 16'hdbff;
  localparam logic [15:0] LO_SUR_MIN = 16'hdc00;
  localparam logic [15:0] LO_SUR_MAX = 16'hdfff;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // UTF-8 length bounds
  localparam logic [20:0] CP_1B_MAX = 21'h7f;
  localparam logic [20:0] CP_2B_MAX = 21'h7ff;
  localparam logic [20:0] CP_3B_MAX = 21'hffff;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] LEAD_2B = 8'hc0;
  localparam logic [7:0] LEAD_3B = 8'he0;
  localparam logic [7:0] LEAD_4B = 8'hf0;
  localparam logic [7:0] CONT_B  = 8'h80;

  // Decoder phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX_HI  = 4'd3,
    PH_WANT_BS = 4'd4,
    PH_WANT_U  = 4'd5,
    PH_HEX_LO  = 4'd6
  } phase_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // Result following the data bytes of one item
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_DONE = 2'd1,
    TAIL_ERR  = 2'd2
  } tail_e;

  // All results caused by one item
  typedef struct packed {
    logic [2:0]                       nbytes;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    tail_e                            tail;
    logic [LEN_W-1:0]                 length;
  } grp_t;

  // UTF-8 encoding of one code point
  typedef struct packed {
    logic [2:0]                       n;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] b;
  } utf8_t;

  // Hex digit value; bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // Encode a code point (at most 0x10FFFF) as UTF-8, first byte in slot 0
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= CP_1B_MAX) begin
      r.n    = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp <= CP_2B_MAX) begin
      r.n    = 3'd2;
      r.b[0] = LEAD_2B | {3'b000, cp[10:6]};
      r.b[1] = CONT_B  | {2'b00, cp[5:0]};
    end else if (cp <= CP_3B_MAX) begin
      r.n    = 3'd3;
      r.b[0] = LEAD_3B | {4'b0000, cp[15:12]};
      r.b[1] = CONT_B  | {2'b00, cp[11:6]};
      r.b[2] = CONT_B  | {2'b00, cp[5:0]};
    end else begin
      r.n    = 3'd4;
      r.b[0] = LEAD_4B | {5'b00000, cp[20:18]};
      r.b[1] = CONT_B  | {2'b00, cp[17:12]};
      r.b[2] = CONT_B  | {2'b00, cp[11:6]};
      r.b[3] = CONT_B  | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- sv/jsu_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if: input request channel
// Carries one byte of JSON text and its end-of-text flag per request.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

// ----- sv/jsu_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if: result request channel
// Carries one decoded byte, completion or error result per request.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic [9:0] length;
  logic       run_last;

  modport source (output valid, output out_byte, output status, output length,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input status, input length,
                  input run_last, output ready);
endinterface

// ----- sv/jsu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_core: unescape decoder
// Holds the limit register and the string state, and turns each accepted
// byte into a group of up to four UTF-8 bytes plus a completion or error.
// ----------------------------------------------------------------------------
module jsu_core
  import jsu_pkg::*;
#(
  parameter int unsigned MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             text_end_i,
  output grp_t             grp_o,
  output logic             grp_load_o
);

  // written count and comparison widths
  localparam int unsigned WW  = $clog2(MAX_LIMIT);
  localparam int unsigned LB  = $clog2(MAX_LIMIT + 1);
  localparam int unsigned CW  = ((LB > CFG_W) ? LB : CFG_W) + 1;

  logic [CFG_W-1:0] limit_q;
  phase_e           phase_q, phase_d;
  logic [15:0]      acc_q, acc_d;
  logic [9:0]       hh_q, hh_d;
  logic [1:0]       hd_q, hd_d;
  logic [WW-1:0]    wr_q, wr_d;

  logic [CW-1:0]    lim;
  logic [CW-1:0]    sum;
  logic [4:0]       nib;
  logic [15:0]      acc_new;
  logic [20:0]      cp;
  utf8_t            enc;
  logic             emit_code, emit_raw, do_fail;
  logic [2:0]       e_n;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] e_b;
  logic             e_bad;
  grp_t             grp;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Effective limit, saturated at the cap
  always_comb begin
    if (CW'(limit_q) > CW'(MAX_LIMIT)) begin
      lim = CW'(MAX_LIMIT);
    end else begin
      lim = CW'(limit_q);
    end
  end

  // Decode one byte
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    hh_d      = hh_q;
    hd_d      = hd_q;
    wr_d      = wr_q;
    grp       = '0;
    grp.tail  = TAIL_NONE;
    do_fail   = 1'b0;
    emit_code = 1'b0;
    emit_raw  = 1'b0;
    cp        = '0;
    nib       = hex_value(in_byte_i);
    acc_new   = {acc_q[11:0], nib[3:0]};

    case (phase_q)
      PH_STR: begin
        if (in_byte_i == CH_QUOTE) begin
          grp.tail   = TAIL_DONE;
          grp.length = LEN_W'(CW'(wr_q));
          phase_d    = PH_IDLE;
          wr_d       = '0;
        end else if (in_byte_i < CH_SPACE) begin
          do_fail = 1'b1;
        end else if (in_byte_i == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else begin
          emit_raw = 1'b1;
        end
      end
      PH_ESC: begin
        emit_code = 1'b1;
        case (in_byte_i)
          CH_QUOTE, CH_BSLASH, CH_SLASH: cp = 21'(in_byte_i);
          CH_LO_B: cp = 21'(CH_BS);
          CH_LO_F: cp = 21'(CH_FF);
          CH_LO_N: cp = 21'(CH_LF);
          CH_LO_R: cp = 21'(CH_CR);
          CH_LO_T: cp = 21'(CH_TAB);
          CH_LO_U: begin
            emit_code = 1'b0;
            phase_d   = PH_HEX_HI;
            acc_d     = '0;
            hd_d      = '0;
          end
          default: begin
            emit_code = 1'b0;
            do_fail   = 1'b1;
          end
        endcase
      end
      PH_HEX_HI, PH_HEX_LO: begin
        if (nib[4]) begin
          do_fail = 1'b1;
        end else if (hd_q != 2'd3) begin
          hd_d  = hd_q + 2'd1;
          acc_d = acc_new;
        end else begin
          hd_d  = '0;
          acc_d = '0;
          if (phase_q == PH_HEX_HI) begin
            if (acc_new >= HI_SUR_MIN && acc_new <= HI_SUR_MAX) begin
              hh_d    = acc_new[9:0];
              phase_d = PH_WANT_BS;
            end else if (acc_new >= LO_SUR_MIN && acc_new <= LO_SUR_MAX) begin
              do_fail = 1'b1;
            end else begin
              emit_code = 1'b1;
              cp        = 21'(acc_new);
            end
          end else begin
            if (acc_new < LO_SUR_MIN || acc_new > LO_SUR_MAX) begin
              do_fail = 1'b1;
            end else begin
              emit_code = 1'b1;
              cp        = SUPP_BASE + {1'b0, hh_q, acc_new[9:0]};
            end
          end
        end
      end
      PH_WANT_BS: begin
        if (in_byte_i == CH_BSLASH) begin
          phase_d = PH_WANT_U;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_WANT_U: begin
        if (in_byte_i == CH_LO_U) begin
          phase_d = PH_HEX_LO;
          acc_d   = '0;
          hd_d    = '0;
        end else begin
          do_fail = 1'b1;
        end
      end
      default: begin
        // idle: skip blanks, open on a quote if the limit is nonzero, else fail
        phase_d = PH_IDLE;
        if (in_byte_i inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
          phase_d = PH_IDLE;
        end else if (in_byte_i == CH_QUOTE && lim != '0) begin
          phase_d = PH_STR;
          wr_d    = '0;
          acc_d   = '0;
          hh_d    = '0;
          hd_d    = '0;
        end else begin
          do_fail = 1'b1;
        end
      end
    endcase

    // Character bytes: raw pass-through or UTF-8 encoding
    enc = utf8_encode(cp);
    if (emit_raw) begin
      e_n   = 3'd1;
      e_b   = '0;
      e_b[0] = in_byte_i;
      e_bad = 1'b0;
    end else begin
      e_n   = enc.n;
      e_b   = enc.b;
      e_bad = (cp == '0);
    end
    sum = CW'(wr_q) + CW'(e_n);

    // Overflow and NUL check; nothing of a rejected character goes out
    if (emit_raw || emit_code) begin
      if (e_bad || sum >= lim) begin
        do_fail = 1'b1;
      end else begin
        grp.nbytes = e_n;
        grp.bytes  = e_b;
        wr_d       = sum[WW-1:0];
        phase_d    = PH_STR;
      end
    end

    // Text ran out before the string closed
    if (text_end_i && grp.tail == TAIL_NONE) begin
      do_fail = 1'b1;
    end

    if (do_fail) begin
      grp.tail   = TAIL_ERR;
      grp.length = '0;
      phase_d    = PH_IDLE;
      acc_d      = '0;
      hh_d       = '0;
      hd_d       = '0;
      wr_d       = '0;
    end
  end

  // String state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      hh_q    <= '0;
      hd_q    <= '0;
      wr_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hh_q    <= hh_d;
      hd_q    <= hd_d;
      wr_q    <= wr_d;
    end
  end

  assign grp_o      = grp;
  assign grp_load_o = accept_i && (grp.nbytes != '0 || grp.tail != TAIL_NONE);

endmodule

// ----- sv/jsu_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emit: result register and serializer
// Holds the result group of one item and hands its results out one per
// request, marking the last one.
// ----------------------------------------------------------------------------
module jsu_emit
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  grp_t        grp_i,
  output logic        free_o,
  jsu_out_if.source   out_o
);

  grp_t       grp_q;
  logic       valid_q;
  logic [2:0] idx_q;
  logic [2:0] cnt;
  logic       last;
  logic       take;

  // Results in the held group and position of the current one
  assign cnt  = grp_q.nbytes + {2'b00, grp_q.tail != TAIL_NONE};
  assign last = (idx_q == cnt - 3'd1);
  assign take = valid_q && out_o.ready;

  // Room for a new group once the last result leaves
  assign free_o = !valid_q || (out_o.ready && last);

  // Group register and position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (last) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  // Current result
  always_comb begin
    out_o.valid    = valid_q;
    out_o.run_last = last;
    out_o.out_byte = '0;
    out_o.length   = '0;
    out_o.status   = ST_DATA;
    if (idx_q < grp_q.nbytes) begin
      out_o.out_byte = grp_q.bytes[idx_q[1:0]];
    end else if (grp_q.tail == TAIL_DONE) begin
      out_o.status = ST_DONE;
      out_o.length = grp_q.length;
    end else begin
      out_o.status = ST_ERR;
    end
  end

endmodule

// ----- sv/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string unescaper to UTF-8
// Decodes one JSON string from a byte stream into UTF-8 bytes, a completion
// with its length, or an error.
// ----------------------------------------------------------------------------
// A byte is accepted in every cycle in which the result register is free or
// its last result is taken in that cycle; decoding is combinational and the
// results of a byte appear in the next. Each byte gives up to five results
// (four UTF-8 bytes and an error), delivered one per cycle while the output
// is ready; the input waits until the last result of a byte is taken, so
// plain text sustains one byte per cycle, set by the single-result port.
// Bytes that yield nothing (blanks, backslashes, hex digits) need no output.
// The limit register may only be written while the block is idle.
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int unsigned MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  jsu_in_if.sink           in_i,
  jsu_out_if.source        out_o
);

  logic accept;
  logic free;
  logic grp_load;
  grp_t grp;

  // Input handshake
  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  jsu_core #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_byte_i  (in_i.in_byte),
    .text_end_i (in_i.text_end),
    .grp_o      (grp),
    .grp_load_o (grp_load)
  );

  jsu_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (grp_load),
    .grp_i  (grp),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule
